[rtl/mss_pkg.sv]
// types and constants shared by the median-of-sample-set block
// depends on nothing
`default_nettype none

package mss_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W  = 7;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]         used_count;
    logic                       overflow;
  } out_word_t;

  // word handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       keep;
    logic                       ovf;
  } q_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

[rtl/mss_fifo.sv]
// short register queue between front and back
// depends on mss_pkg
`default_nettype none

module mss_fifo (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic push,
  input  wire mss_pkg::q_word_t    wr_word,
  output mss_pkg::q_word_t         rd_word,
  input  wire                logic pop,
  output logic                     full,
  output logic                     empty
);

  mss_pkg::q_word_t mem_r [mss_pkg::QDEPTH];
  logic [mss_pkg::QAW-1:0] wptr_r, wptr_nxt;
  logic [mss_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [mss_pkg::QAW:0]   count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == (mss_pkg::QAW+1)'(mss_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_word;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (mss_pkg::QAW+1)'(mss_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (wptr_r == rptr_r))
    else $error("queue full with pointers apart");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wptr_r == rptr_r))
    else $error("queue empty with pointers apart");

endmodule

`default_nettype wire

[rtl/mss_front.sv]
// front: takes sample words, counts the set, marks kept and dropped samples
// depends on mss_pkg
`default_nettype none

module mss_front #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic push,
  input  wire mss_pkg::in_word_t   in_data,
  input  wire                logic q_full,
  output logic                     full,
  output logic                     q_push,
  output mss_pkg::q_word_t         q_word
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic          drop_r, drop_nxt;
  logic          accept, keep;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign keep   = (fill_r < CW'(MAX_SAMPLES));

  // dropped samples that do not close the set never reach the back
  assign q_push        = accept && (keep || in_data.last);
  assign q_word.sample = in_data.sample;
  assign q_word.last   = in_data.last;
  assign q_word.keep   = keep;
  assign q_word.ovf    = drop_r || !keep;

  always_comb begin
    fill_nxt = fill_r;
    drop_nxt = drop_r;
    if (accept) begin
      if (in_data.last) begin
        fill_nxt = '0;
        drop_nxt = 1'b0;
      end else if (keep) begin
        fill_nxt = fill_r + 1'b1;
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      drop_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      drop_r <= drop_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_SAMPLES))
    else $error("front fill count beyond capacity");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (fill_r == CW'(MAX_SAMPLES)))
    else $error("drop flag set with room left");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into a full queue");

endmodule

`default_nettype wire

[rtl/mss_back.sv]
// back: insertion chain that keeps the set sorted, then shifts out the median
// depends on mss_pkg
`default_nettype none

module mss_back #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire mss_pkg::q_word_t    q_word,
  input  wire                logic q_empty,
  output logic                     q_pop,
  output logic                     empty,
  input  wire                logic pop,
  output mss_pkg::out_word_t       out_data
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  mss_pkg::back_state_t state_r, state_nxt;

  logic signed [31:0] chain_r   [MAX_SAMPLES];
  logic signed [31:0] ins_val   [MAX_SAMPLES];
  logic signed [31:0] shift_val [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] gt;

  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      lo_idx, hi_idx;
  logic signed [31:0] a_r, a_nxt, a_use;
  logic signed [32:0] pair_sum;
  logic               ovf_r, ovf_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic               outv_r, outv_nxt;
  mss_pkg::out_word_t out_r, out_nxt;
  logic [CW+6:0]      n_ext;
  logic               do_ins, do_shift;

  // per-entry insert and shift values; an entry past the fill reads as +inf
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_chain
    assign gt[i] = (CW'(i) >= n_r) || (chain_r[i] > q_word.sample);
    if (i == 0) begin : g_head
      assign ins_val[i] = gt[i] ? q_word.sample : chain_r[i];
    end else begin : g_body
      assign ins_val[i] = gt[i] ? (gt[i-1] ? chain_r[i-1] : q_word.sample) : chain_r[i];
    end
    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign shift_val[i] = chain_r[i];
    end else begin : g_mid
      assign shift_val[i] = chain_r[i+1];
    end
  end

  assign lo_idx   = (n_r - 1'b1) >> 1;
  assign hi_idx   = n_r >> 1;
  assign a_use    = (k_r == lo_idx) ? chain_r[0] : a_r;
  assign pair_sum = {a_use[31], a_use} + {chain_r[0][31], chain_r[0]};
  assign n_ext    = {7'b0, n_r};

  assign empty    = !outv_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    a_nxt     = a_r;
    ovf_nxt   = ovf_r;
    res_nxt   = res_r;
    outv_nxt  = outv_r && !pop;
    out_nxt   = out_r;
    q_pop     = 1'b0;
    do_ins    = 1'b0;
    do_shift  = 1'b0;
    unique case (state_r)
      mss_pkg::ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_word.keep) begin
            do_ins = 1'b1;
            n_nxt  = n_r + 1'b1;
          end
          if (q_word.last) begin
            ovf_nxt   = q_word.ovf;
            k_nxt     = '0;
            state_nxt = mss_pkg::ST_READ;
          end
        end
      end
      mss_pkg::ST_READ: begin
        do_shift = 1'b1;
        k_nxt    = k_r + 1'b1;
        if (k_r == lo_idx) begin
          a_nxt = chain_r[0];
        end
        if (k_r == hi_idx) begin
          res_nxt   = pair_sum[32:1];
          state_nxt = mss_pkg::ST_DONE;
        end
      end
      mss_pkg::ST_DONE: begin
        if (!outv_r || pop) begin
          outv_nxt           = 1'b1;
          out_nxt.median     = res_r;
          out_nxt.used_count = n_ext[6:0];
          out_nxt.overflow   = ovf_r;
          n_nxt              = '0;
          state_nxt          = mss_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = mss_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mss_pkg::ST_LOAD;
      n_r     <= '0;
      k_r     <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    ovf_r <= ovf_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      if (do_ins) begin
        chain_r[i] <= ins_val[i];
      end else if (do_shift) begin
        chain_r[i] <= shift_val[i];
      end
    end
  end

  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_SAMPLES))
    else $error("chain fill beyond capacity");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mss_pkg::ST_READ) |-> (n_r != '0))
    else $error("readout of an empty chain");

  a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mss_pkg::ST_READ) |-> (k_r <= hi_idx))
    else $error("readout ran past the middle");

  a_no_pop_outside_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == mss_pkg::ST_LOAD))
    else $error("queue popped outside load");

endmodule

`default_nettype wire

[rtl/median_of_sample_set_unit.sv]
// top level of the median-of-sample-set block: front, queue and back
// depends on mss_pkg, mss_front, mss_fifo, mss_back
`default_nettype none

// median of a set of signed 32-bit samples. each input word carries one
// sample; the word with last set closes the set and yields one result word
// holding the median, the number of samples that entered it and an overflow
// flag. up to MAX_SAMPLES samples of a set are kept; later ones are dropped
// (the closing one too) and flag overflow. with an even count the median is
// the floor of the mean of the two middle samples. the front takes one word
// per cycle while the 4-word queue has room. the back drains the queue into a
// sorted insertion chain at one sample per cycle while the queue holds words,
// then shifts the chain down to the middle, then loads the result register.
// the back thus sets the sustained rate; the front keeps taking words of the
// next set until the queue fills. there is no memory to clear after reset

module median_of_sample_set_unit #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  // sample side
  input  wire                logic push,
  output logic                     full,
  input  wire mss_pkg::in_word_t   in_data,
  // result side
  output logic                     empty,
  input  wire                logic pop,
  output mss_pkg::out_word_t       out_data
);

  // front to queue
  logic             q_push;
  mss_pkg::q_word_t q_wr_word;
  logic             q_full;

  // queue to back
  mss_pkg::q_word_t q_rd_word;
  logic             q_empty;
  logic             q_pop;

  // front counts the set and tags each word as kept, dropped or closing
  mss_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .in_data(in_data),
    .q_full (q_full),
    .full   (full),
    .q_push (q_push),
    .q_word (q_wr_word)
  );

  // short queue so the front keeps taking words while the back sorts
  mss_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_word(q_wr_word),
    .rd_word(q_rd_word),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back sorts the kept samples and holds the result word until popped
  mss_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_word  (q_rd_word),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  // a result word always reports at least one sample when capacity fits 7 bits
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (MAX_SAMPLES < 128)) |-> (out_data.used_count != '0))
    else $error("result word with zero samples");

  // a waiting result word holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result word changed before pop");

  // the sample side stalls only on a full queue
  a_full_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    full == q_full)
    else $error("input stall not from queue");

endmodule

`default_nettype wire

[dv/median_of_sample_set_unit_tb.sv]
// testbench for median_of_sample_set_unit: directed sets, random sets, sets
// past the store capacity and a long result hold-off, checked word by word
// against a behavioral median predictor; depends on mss_pkg and the rtl
`timescale 1ns / 1ps

module median_of_sample_set_unit_tb;

  localparam int unsigned MAX_SAMPLES = 64;
  // back inserts, shifts to the middle and loads each set, plus the queue in front
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic signed [mss_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [mss_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  mss_pkg::in_word_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  mss_pkg::out_word_t out_data;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  // long hold-off requests, counted in the pop process
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  bit failed = 1'b0;

  // predictor state: samples kept in the open set
  logic signed [mss_pkg::SAMPLE_W-1:0] kept_samples [MAX_SAMPLES];
  int unsigned kept_count = 0;
  bit set_dropped = 1'b0;
  mss_pkg::out_word_t median_q [$];

  median_of_sample_set_unit #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // median of the kept samples: insertion sort, then middle or floored mean
  function automatic logic signed [mss_pkg::SAMPLE_W-1:0] median_of_kept();
    logic signed [mss_pkg::SAMPLE_W-1:0] ord [MAX_SAMPLES];
    logic signed [mss_pkg::SAMPLE_W-1:0] v;
    logic signed [mss_pkg::SAMPLE_W:0] pair_sum;
    int j;
    for (int i = 0; i < kept_count; i++) begin
      v = kept_samples[i];
      j = i;
      while (j > 0 && ord[j-1] > v) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    if (kept_count % 2 == 1) return ord[kept_count/2];
    // exact 33-bit sum, arithmetic shift gives the floor
    pair_sum = {ord[(kept_count-1)/2][mss_pkg::SAMPLE_W-1], ord[(kept_count-1)/2]}
             + {ord[kept_count/2][mss_pkg::SAMPLE_W-1], ord[kept_count/2]};
    pair_sum = pair_sum >>> 1;
    return pair_sum[mss_pkg::SAMPLE_W-1:0];
  endfunction

  // update the set state with one accepted word; a closing word queues a median
  function automatic void absorb_sample(mss_pkg::in_word_t w);
    mss_pkg::out_word_t res;
    if (kept_count < MAX_SAMPLES) begin
      kept_samples[kept_count] = w.sample;
      kept_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (w.last) begin
      res.median = median_of_kept();
      res.used_count = kept_count[mss_pkg::COUNT_W-1:0];
      res.overflow = set_dropped;
      median_q.push_back(res);
      kept_count = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // result side: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // compare each popped word with the oldest expected median
  always @(posedge clk) begin
    mss_pkg::out_word_t want;
    if (rst_n && pop && !empty) begin
      if (median_q.size() == 0) begin
        $error("unexpected result word: median %0d, used_count %0d, overflow %0b",
               out_data.median, out_data.used_count, out_data.overflow);
        failed = 1'b1;
      end else begin
        want = median_q.pop_front();
        if (out_data.median !== want.median) begin
          $error("median: expected %0d, got %0d", want.median, out_data.median);
          failed = 1'b1;
        end
        if (out_data.used_count !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count,
                 out_data.used_count);
          failed = 1'b1;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
          failed = 1'b1;
        end
      end
    end
  end

  // offer one word from a falling edge, with random idle cycles in front;
  // returns at the falling edge after the word is taken, push still high
  task automatic send_word(input logic signed [mss_pkg::SAMPLE_W-1:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= mss_pkg::in_word_t'{sample: s, last: l};
    do @(posedge clk); while (full);
    absorb_sample(mss_pkg::in_word_t'{sample: s, last: l});
    @(negedge clk);
  endtask

  // sample values weighted toward the extremes and toward repeats
  function automatic logic signed [mss_pkg::SAMPLE_W-1:0] pick_sample();
    unique case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return $signed($urandom_range(16)) - 8;
      3: return S_MAX - $urandom_range(3);
      4: return S_MIN + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(pick_sample(), i == n - 1);
  endtask

  // mostly short sets, some near the capacity, a few past it
  function automatic int unsigned pick_set_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(40, 9);
    if (r < 97) return $urandom_range(MAX_SAMPLES, MAX_SAMPLES - 4);
    return $urandom_range(MAX_SAMPLES + 8, MAX_SAMPLES + 1);
  endfunction

  task automatic test_directed();
    send_word(S_MAX, 1'b1);                       // single sample, top
    send_word(S_MIN, 1'b1);                       // single sample, bottom
    send_word(S_MIN, 1'b0); send_word(S_MAX, 1'b1); // floored mean of extremes is -1
    send_word(S_MAX, 1'b0); send_word(S_MAX, 1'b1); // sum needs the 33rd bit
    send_word(S_MIN, 1'b0); send_word(S_MIN, 1'b1);
    send_word(5, 1'b0); send_word(-3, 1'b0); send_word(0, 1'b1);
    send_word(-1, 1'b0); send_word(-2, 1'b1);     // negative half rounds down
    send_word(7, 1'b0); send_word(1, 1'b0); send_word(4, 1'b0); send_word(2, 1'b1);
    send_word(32'sh5555_5555, 1'b0); send_word(32'shaaaa_aaaa, 1'b0);
    send_word(3, 1'b1);
  endtask

  // exactly full, then one over so the closing word is dropped, then well over
  task automatic test_store_full();
    send_set(MAX_SAMPLES);
    send_set(MAX_SAMPLES + 1);
    send_set(MAX_SAMPLES + 6);
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned words);
    int unsigned sent;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < words) begin
      automatic int unsigned n = pick_set_len();
      send_set(n);
      sent += n;
    end
  endtask

  // results held back for a long stretch while short sets keep coming,
  // so the queue fills and full stalls the sample side
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 30; i++) send_set($urandom_range(3, 1));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_store_full();
    test_random(0, 0, 230);
    test_random(72, 0, 230);
    test_random(0, 72, 230);
    test_random(15, 15, 230);
    test_backpressure();
    push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (median_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
